FILE: rtl/cafe_pkg.sv
// Package for the 8-bit execute core: word types for both channels,
// operation codes and status flag bit positions. No dependencies.
package cafe_pkg;

    // Operation codes carried in the action field.
    localparam logic [4:0] ACT_ADC     = 5'd0;
    localparam logic [4:0] ACT_AND     = 5'd1;
    localparam logic [4:0] ACT_ASL_ACC = 5'd2;
    localparam logic [4:0] ACT_ASL_MEM = 5'd3;
    localparam logic [4:0] ACT_BIT     = 5'd4;
    localparam logic [4:0] ACT_CMP     = 5'd5;
    localparam logic [4:0] ACT_CPX     = 5'd6;
    localparam logic [4:0] ACT_CPY     = 5'd7;
    localparam logic [4:0] ACT_DEC     = 5'd8;
    localparam logic [4:0] ACT_DEX     = 5'd9;
    localparam logic [4:0] ACT_DEY     = 5'd10;
    localparam logic [4:0] ACT_CLC     = 5'd11;
    localparam logic [4:0] ACT_CLD     = 5'd12;
    localparam logic [4:0] ACT_CLI     = 5'd13;
    localparam logic [4:0] ACT_CLV     = 5'd14;
    localparam logic [4:0] ACT_BCC     = 5'd15;
    localparam logic [4:0] ACT_BCS     = 5'd16;
    localparam logic [4:0] ACT_BEQ     = 5'd17;
    localparam logic [4:0] ACT_BMI     = 5'd18;
    localparam logic [4:0] ACT_BNE     = 5'd19;
    localparam logic [4:0] ACT_BPL     = 5'd20;
    localparam logic [4:0] ACT_BVC     = 5'd21;
    localparam logic [4:0] ACT_BVS     = 5'd22;

    // Status register bit positions, NV-BDIZC layout.
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    typedef struct packed {
        logic [4:0]  action;
        logic [7:0]  operand;
        logic [15:0] address;
    } item_t;

    typedef struct packed {
        logic [7:0]  write_data;
        logic [15:0] write_address;
        logic        write_enable;
        logic        branch_taken;
        logic [7:0]  status;
        logic [7:0]  accumulator;
    } result_t;

endpackage

FILE: rtl/cpu8_alu_flag_execute_core.sv
// Execute stage of an 8-bit processor: accumulator, X, Y and status flags.
// Depends on cafe_pkg for the word types, operation codes and flag positions.
//
// Usage: an operation word (action, operand byte, operand address) enters on
// the item channel and exactly one result word leaves on the result channel,
// in the same order. A word is taken at a rising edge where valid is high and
// stall is low. The result carries the store request (data, address, enable)
// for ASL memory and DEC, the branch condition for the eight branch actions,
// and the status and accumulator values after the operation.
//
// An item is captured in an input register, executed by one pass of 8-bit
// add, logic and flag logic, and the result lands in the output register.
// Throughput is one word per cycle while the receiver does not stall; the
// architectural registers are updated in the same cycle the word moves into
// the output register, so back-to-back words see each other's effects.
//
// Reset clears the accumulator, X, Y, the status register and both valid
// bits. When the receiver stalls, the output register holds its word, the
// input register fills, and then item_stall rises until the result is taken.
module cpu8_alu_flag_execute_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  cafe_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output cafe_pkg::result_t result
);
    import cafe_pkg::*;

    // Input register.
    logic  stage_valid_reg;
    item_t stage_reg;

    // Output register.
    logic    out_valid_reg;
    result_t out_reg;

    // Architectural state.
    logic [7:0] acc_reg;
    logic [7:0] x_reg;
    logic [7:0] y_reg;
    logic [7:0] flag_reg;

    logic [7:0] acc_next;
    logic [7:0] x_next;
    logic [7:0] y_next;
    logic [7:0] flag_next;
    result_t    out_next;

    logic advance;
    logic item_take;

    logic [8:0] sum;
    logic [8:0] diff;
    logic [7:0] cmp_src;
    logic [7:0] shift_src;
    logic [7:0] shift_res;
    logic [7:0] dec_src;
    logic [7:0] dec_res;
    logic [7:0] zn_val;
    logic       zn_load;

    // The output register can take a new word when it is empty or is being read.
    assign advance    = !out_valid_reg || !result_stall;
    assign item_stall = stage_valid_reg && !advance;
    assign item_take  = item_valid && !item_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Shared datapath pieces; the operand sources are picked by action.
    always_comb
    begin
        sum = {1'b0, acc_reg} + {1'b0, stage_reg.operand} + {8'd0, flag_reg[FLAG_C]};

        cmp_src = acc_reg;
        if (stage_reg.action == ACT_CPX)
        begin
            cmp_src = x_reg;
        end
        else if (stage_reg.action == ACT_CPY)
        begin
            cmp_src = y_reg;
        end
        diff = {1'b0, cmp_src} - {1'b0, stage_reg.operand};

        shift_src = (stage_reg.action == ACT_ASL_ACC) ? acc_reg : stage_reg.operand;
        shift_res = {shift_src[6:0], 1'b0};

        dec_src = stage_reg.operand;
        if (stage_reg.action == ACT_DEX)
        begin
            dec_src = x_reg;
        end
        else if (stage_reg.action == ACT_DEY)
        begin
            dec_src = y_reg;
        end
        dec_res = dec_src - 8'd1;
    end

    // Operation decode: next architectural state and the result word.
    always_comb
    begin
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        flag_next = flag_reg;
        zn_val    = 8'd0;
        zn_load   = 1'b0;

        out_next               = '0;
        out_next.write_address = stage_reg.address;

        unique case (stage_reg.action)
            ACT_ADC:
            begin
                acc_next          = sum[7:0];
                flag_next[FLAG_C] = sum[8];
                flag_next[FLAG_V] = !(acc_reg[7] ^ stage_reg.operand[7])
                                    && (acc_reg[7] ^ sum[7]);
                zn_val            = sum[7:0];
                zn_load           = 1'b1;
            end
            ACT_AND:
            begin
                acc_next = acc_reg & stage_reg.operand;
                zn_val   = acc_reg & stage_reg.operand;
                zn_load  = 1'b1;
            end
            ACT_ASL_ACC, ACT_ASL_MEM:
            begin
                flag_next[FLAG_C] = shift_src[7];
                zn_val            = shift_res;
                zn_load           = 1'b1;
                if (stage_reg.action == ACT_ASL_ACC)
                begin
                    acc_next = shift_res;
                end
                else
                begin
                    out_next.write_data   = shift_res;
                    out_next.write_enable = 1'b1;
                end
            end
            ACT_BIT:
            begin
                flag_next[FLAG_Z] = (acc_reg & stage_reg.operand) == 8'd0;
                flag_next[FLAG_N] = stage_reg.operand[7];
                flag_next[FLAG_V] = stage_reg.operand[6];
            end
            ACT_CMP, ACT_CPX, ACT_CPY:
            begin
                flag_next[FLAG_C] = !diff[8];
                zn_val            = diff[7:0];
                zn_load           = 1'b1;
            end
            ACT_DEC:
            begin
                out_next.write_data   = dec_res;
                out_next.write_enable = 1'b1;
                zn_val                = dec_res;
                zn_load               = 1'b1;
            end
            ACT_DEX:
            begin
                x_next  = dec_res;
                zn_val  = dec_res;
                zn_load = 1'b1;
            end
            ACT_DEY:
            begin
                y_next  = dec_res;
                zn_val  = dec_res;
                zn_load = 1'b1;
            end
            ACT_CLC: flag_next[FLAG_C] = 1'b0;
            ACT_CLD: flag_next[FLAG_D] = 1'b0;
            ACT_CLI: flag_next[FLAG_I] = 1'b0;
            ACT_CLV: flag_next[FLAG_V] = 1'b0;
            ACT_BCC: out_next.branch_taken = !flag_reg[FLAG_C];
            ACT_BCS: out_next.branch_taken = flag_reg[FLAG_C];
            ACT_BEQ: out_next.branch_taken = flag_reg[FLAG_Z];
            ACT_BMI: out_next.branch_taken = flag_reg[FLAG_N];
            ACT_BNE: out_next.branch_taken = !flag_reg[FLAG_Z];
            ACT_BPL: out_next.branch_taken = !flag_reg[FLAG_N];
            ACT_BVC: out_next.branch_taken = !flag_reg[FLAG_V];
            ACT_BVS: out_next.branch_taken = flag_reg[FLAG_V];
            default:
            begin
                // Unused codes leave all state alone.
            end
        endcase

        if (zn_load)
        begin
            flag_next[FLAG_Z] = (zn_val == 8'd0);
            flag_next[FLAG_N] = zn_val[7];
        end

        out_next.status      = flag_next;
        out_next.accumulator = acc_next;
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            acc_reg         <= 8'd0;
            x_reg           <= 8'd0;
            y_reg           <= 8'd0;
            flag_reg        <= 8'd0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= stage_valid_reg;
            end
            if (!item_stall)
            begin
                stage_valid_reg <= item_valid;
            end
            if (advance && stage_valid_reg)
            begin
                acc_reg  <= acc_next;
                x_reg    <= x_next;
                y_reg    <= y_next;
                flag_reg <= flag_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            stage_reg <= item;
        end
        if (advance && stage_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

endmodule
